// ===== rtl/core/sldf_pkg.sv =====
// Package for the start/length/XOR-check frame deframer.
// Phase and event codes, start byte, and the state and result structs.
// No dependencies.
`default_nettype none

package sldf_pkg;

	localparam logic [7:0] START_BYTE = 8'hFE;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_LENLO = 3'd1,
		PH_LENHI = 3'd2,
		PH_CMD0  = 3'd3,
		PH_CMD1  = 3'd4,
		PH_BODY  = 3'd5
	} phase_t;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_HEADER  = 3'd1;
	localparam logic [2:0] EV_PAYLOAD = 3'd2;
	localparam logic [2:0] EV_GOOD    = 3'd3;
	localparam logic [2:0] EV_BAD     = 3'd4;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  chk;
		logic [15:0] exp_len;
		logic [15:0] cnt;
		logic [7:0]  cmd0;
		logic [7:0]  cmd1;
	} dfr_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  pbyte;
		logic [15:0] pidx;
	} dfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sof_length_xor_frame_deframer.sv =====
// Top level of the start/length/XOR-check frame deframer.
// Depends on sldf_pkg and sldf_step.
//
// Usage:
//  Input channel (in_valid/in_ready): one word per handshake, either a
//  received byte (action 0, rx_byte) or an abort (action 1).
//  Output channel (out_valid/out_ready): exactly one result word per input
//  word: event_kind, payload_byte, payload_index, and the current
//  command_0, command_1 and frame_length.
//  A word is taken into an input register; the frame state is updated and
//  the result written to the output register when that register can take
//  it, that is when it is empty or the receiver takes its word.
//  Throughput is one word per cycle while the receiver does not stall; the
//  per-word logic is one byte XOR, one 16-bit compare and increment.
//  When the receiver stalls, the output register holds its word, the input
//  register fills, and in_ready drops; no word is lost or repeated.
//  Reset clears both registers' valid flags and returns the frame state to
//  hunting for the start byte with all counters and fields at zero.
`default_nettype none

module sof_length_xor_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  rx_byte,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [2:0]  event_kind,
	output      logic [7:0]  payload_byte,
	output      logic [15:0] payload_index,
	output      logic [7:0]  command_0,
	output      logic [7:0]  command_1,
	output      logic [15:0] frame_length
);
	import sldf_pkg::*;

	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	dfr_result_t res_s2;
	dfr_state_t  st_q;
	dfr_state_t  st_nxt;
	dfr_result_t res_nxt;
	logic        adv;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	sldf_step u_step (
		.st_cur  (st_q),
		.action  (action_s1),
		.rx_byte (byte_s1),
		.st_nxt  (st_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			byte_s1   <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			st_q     <= '{phase: PH_HUNT, default: '0};
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// fields track the stored state, which only moves with a new result
	assign out_valid     = valid_s2;
	assign event_kind    = res_s2.kind;
	assign payload_byte  = res_s2.pbyte;
	assign payload_index = res_s2.pidx;
	assign command_0     = st_q.cmd0;
	assign command_1     = st_q.cmd1;
	assign frame_length  = st_q.exp_len;

`ifndef SYNTH
	a_pidx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_PAYLOAD |-> payload_index < frame_length)
		else $error("payload index beyond frame length");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_PAYLOAD |->
			payload_index == 16'd0 && payload_byte == 8'd0)
		else $error("payload fields set on non-payload event");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase <= PH_BODY)
		else $error("unreachable phase code");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(action_s1))
		else $error("input register changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sldf_step.sv =====
// Per-word next-state and event logic of the frame deframer.
// Depends on sldf_pkg.
`default_nettype none

module sldf_step (
	input  wire sldf_pkg::dfr_state_t  st_cur,
	input  wire logic                  action,
	input  wire logic [7:0]            rx_byte,
	output      sldf_pkg::dfr_state_t  st_nxt,
	output      sldf_pkg::dfr_result_t res
);
	import sldf_pkg::*;

	logic [7:0] chk_x;

	assign chk_x = st_cur.chk ^ rx_byte;

	always_comb begin
		st_nxt = st_cur;
		res    = '0;
		if (action) begin
			st_nxt.phase = PH_HUNT;
		end else begin
			case (st_cur.phase)
				PH_LENLO: begin
					st_nxt.chk     = chk_x;
					st_nxt.exp_len = {8'h00, rx_byte};
					st_nxt.phase   = PH_LENHI;
				end
				PH_LENHI: begin
					st_nxt.chk     = chk_x;
					st_nxt.exp_len = {rx_byte, st_cur.exp_len[7:0]};
					st_nxt.cnt     = '0;
					st_nxt.phase   = PH_CMD0;
				end
				PH_CMD0: begin
					st_nxt.chk   = chk_x;
					st_nxt.cmd0  = rx_byte;
					st_nxt.phase = PH_CMD1;
				end
				PH_CMD1: begin
					st_nxt.chk   = chk_x;
					st_nxt.cmd1  = rx_byte;
					st_nxt.phase = PH_BODY;
					res.kind     = EV_HEADER;
				end
				PH_BODY: begin
					st_nxt.chk = chk_x;
					if (st_cur.cnt < st_cur.exp_len) begin
						res.kind   = EV_PAYLOAD;
						res.pbyte  = rx_byte;
						res.pidx   = st_cur.cnt;
						st_nxt.cnt = st_cur.cnt + 16'd1;
					end else begin
						// check byte
						st_nxt.phase = PH_HUNT;
						res.kind     = (chk_x == 8'h00) ? EV_GOOD : EV_BAD;
					end
				end
				default: begin
					st_nxt.phase = PH_HUNT;
					if (rx_byte == START_BYTE) begin
						st_nxt.phase   = PH_LENLO;
						st_nxt.chk     = '0;
						st_nxt.exp_len = '0;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for sof_length_xor_frame_deframer: directed frames, then random frame traffic.
// A built-in frame predictor checks every result word in order.
// Depends on sldf_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb;
	import sldf_pkg::*;

	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_ABORT = 1'b1;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_SQUARE} rx_mode_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  pbyte;
		logic [15:0] pidx;
		logic [7:0]  cmd0;
		logic [7:0]  cmd1;
		logic [15:0] flen;
	} deframe_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = ACT_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [7:0]  command_0;
	logic [7:0]  command_1;
	logic [15:0] frame_length;

	// frame tracker state
	phase_t      trk_phase = PH_HUNT;
	logic [7:0]  trk_check = '0;
	logic [15:0] trk_length = '0;
	logic [15:0] trk_count = '0;
	logic [7:0]  trk_cmd0 = '0;
	logic [7:0]  trk_cmd1 = '0;

	deframe_word_t expected_words[$];

	int burst_left = 0;
	int words_sent = 0;
	int words_seen = 0;
	int mismatches = 0;
	int n_header = 0, n_payload = 0, n_good = 0, n_bad = 0, n_abort = 0;

	sof_length_xor_frame_deframer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .payload_byte(payload_byte),
		.payload_index(payload_index), .command_0(command_0),
		.command_1(command_1), .frame_length(frame_length)
	);

	always #5 clk = ~clk;

	function automatic void track_frame(input logic act, input logic [7:0] b);
		deframe_word_t r;
		r = '0;
		r.kind = EV_NONE;
		if (act == ACT_ABORT) begin
			trk_phase = PH_HUNT;
			n_abort++;
		end else if (trk_phase == PH_HUNT) begin
			if (b == START_BYTE) begin
				trk_phase = PH_LENLO;
				trk_check = '0;
				trk_length = '0;
			end
		end else begin
			trk_check = trk_check ^ b;
			case (trk_phase)
			PH_LENLO: begin
				trk_length = {8'h00, b};
				trk_phase = PH_LENHI;
			end
			PH_LENHI: begin
				trk_length[15:8] = b;
				trk_count = '0;
				trk_phase = PH_CMD0;
			end
			PH_CMD0: begin
				trk_cmd0 = b;
				trk_phase = PH_CMD1;
			end
			PH_CMD1: begin
				trk_cmd1 = b;
				trk_phase = PH_BODY;
				r.kind = EV_HEADER;
			end
			default: begin
				if (trk_count < trk_length) begin
					r.kind = EV_PAYLOAD;
					r.pbyte = b;
					r.pidx = trk_count;
					trk_count = trk_count + 16'd1;
				end else begin
					trk_phase = PH_HUNT;
					r.kind = (trk_check == 8'h00) ? EV_GOOD : EV_BAD;
				end
			end
			endcase
		end
		r.cmd0 = trk_cmd0;
		r.cmd1 = trk_cmd1;
		r.flen = trk_length;
		expected_words.push_back(r);
	endfunction

	function automatic void report_error(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// sender: bursts with random gaps
	task automatic send_word(input logic act, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_frame(act, b);
		words_sent++;
		burst_left--;
	endtask

	task automatic send_frame(input int len, input logic [7:0] c0, input logic [7:0] c1,
			input bit corrupt, input int abort_at, output int sent);
		logic [7:0] body[$];
		logic [7:0] chk;
		int n_pay;
		body = {START_BYTE, len[7:0], len[15:8], c0, c1};
		n_pay = (len > 64) ? 64 : len;
		for (int i = 0; i < n_pay; i++) body.push_back(8'($urandom));
		chk = '0;
		for (int i = 1; i < body.size(); i++) chk = chk ^ body[i];
		if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
		body.push_back(chk);
		sent = 0;
		for (int i = 0; i < body.size(); i++) begin
			sent++;
			if (i == abort_at) begin
				send_word(ACT_ABORT, 8'($urandom));
				break;
			end
			send_word(ACT_BYTE, body[i]);
		end
	endtask

	task automatic test_hunt_noise;
		send_word(ACT_BYTE, 8'h00);
		send_word(ACT_BYTE, 8'hFF);
		send_word(ACT_ABORT, 8'hFE);
		send_word(ACT_BYTE, 8'hFD);
	endtask

	task automatic test_empty_frame;
		logic [7:0] seq[$];
		seq = {START_BYTE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
		foreach (seq[i]) send_word(ACT_BYTE, seq[i]);
	endtask

	task automatic test_header_extremes;
		logic [7:0] seq[$];
		seq = {START_BYTE, 8'h00, 8'hFF, 8'hA5, 8'h5A};
		foreach (seq[i]) send_word(ACT_BYTE, seq[i]);
		send_word(ACT_ABORT, 8'h00);
	endtask

	task automatic test_bad_check;
		logic [7:0] seq[$];
		// good check would be 0x02
		seq = {START_BYTE, 8'h02, 8'h00, 8'h81, 8'h7E, 8'h00, 8'hFF, 8'h00};
		foreach (seq[i]) send_word(ACT_BYTE, seq[i]);
	endtask

	task automatic test_random_traffic(input int target);
		int framed, pick, len, abort_at, sent, n_noise;
		bit corrupt;
		framed = 0;
		while (framed < target) begin
			pick = $urandom_range(0, 99);
			corrupt = 1'b0;
			abort_at = -1;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			if (pick < 10) begin
				n_noise = $urandom_range(1, 4);
				repeat (n_noise) begin
					if ($urandom_range(0, 3) == 0)
						send_word(ACT_ABORT, 8'($urandom));
					else
						send_word(ACT_BYTE, 8'($urandom));
				end
				continue;
			end
			if (pick < 22) begin
				corrupt = 1'b1;
			end else if (pick < 32) begin
				abort_at = $urandom_range(1, len + 5);
			end else if (pick < 40) begin
				len = $urandom_range(0, 65535);
				abort_at = $urandom_range(1, 24);
			end
			send_frame(len, 8'($urandom), 8'($urandom), corrupt, abort_at, sent);
			framed += sent;
		end
	endtask

	// receiver stall pattern
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= rx_left[2];
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		deframe_word_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {event_kind, payload_byte, payload_index, command_0, command_1, frame_length};
			words_seen++;
			if (expected_words.size() == 0) begin
				report_error($sformatf("unexpected result word, kind %0d", got.kind));
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					report_error($sformatf({"word %0d: expected kind %0d byte %02h idx %0d",
						" cmd %02h/%02h len %0d, got kind %0d byte %02h idx %0d",
						" cmd %02h/%02h len %0d"}, words_seen,
						want.kind, want.pbyte, want.pidx, want.cmd0, want.cmd1, want.flen,
						got.kind, got.pbyte, got.pidx, got.cmd0, got.cmd1, got.flen));
				end
				case (want.kind)
				EV_HEADER:  n_header++;
				EV_PAYLOAD: n_payload++;
				EV_GOOD:    n_good++;
				EV_BAD:     n_bad++;
				default:    ;
				endcase
			end
		end
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hunt_noise;
		test_empty_frame;
		test_header_extremes;
		test_bad_check;
		test_random_traffic(1250);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_words.size() != 0)
			report_error("result words still outstanding");
		$display("Sent %0d words (%0d aborts); checked %0d results.", words_sent, n_abort,
			words_seen);
		$display("Saw %0d headers, %0d payload bytes, %0d good and %0d bad frames.",
			n_header, n_payload, n_good, n_bad);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sldf_pkg.sv
rtl/core/sldf_step.sv
rtl/core/sof_length_xor_frame_deframer.sv
sim/tb.sv
